// File: design/sjte_pkg.sv
// shared types and constants of the shift-jis text cursor engine
package sjte_pkg;

    // input mode codes (carried in tuser)
    localparam logic [1:0] MODE_TEXT   = 2'd0;
    localparam logic [1:0] MODE_LOCATE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_DRAW   = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TOP_ROW    = 3'd0;
    localparam logic [2:0] REG_LAST_ROW   = 3'd1;
    localparam logic [2:0] REG_WIN_EN     = 3'd2;
    localparam logic [2:0] REG_AUTO_WRAP  = 3'd3;
    localparam logic [2:0] REG_TEXT_COLOR = 3'd4;

    // special bytes and colors
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] SCROLL_FILL = 8'h10;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] text_byte;
        logic [5:0] locate_col;
        logic [4:0] locate_row;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] glyph_code;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [7:0]  fill_color;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] lead;
        logic       wrap;
    } t_cursor;

    typedef struct packed {
        logic [4:0] top_row;
        logic [4:0] last_row;
        logic       window_enable;
        logic       auto_wrap;
        logic [7:0] text_color;
    } t_cfg;

    typedef struct packed {
        t_cursor     nxt;
        logic [2:0]  cnt;
        t_result [MAX_RESULTS-1:0] res;
    } t_step_out;

endpackage

// File: design/sjte_in_reg.sv
// input register stage of the text cursor engine
module sjte_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sjte_pkg::t_in_item i_item,
    output logic              o_valid,
    output sjte_pkg::t_in_item o_item,
    input  logic              i_take
);

    logic              r_valid;
    sjte_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: design/sjte_step.sv
// one-pass combinational evaluation of an item: results and next cursor
module sjte_step #(
    parameter int COLUMNS = 40
) (
    input  sjte_pkg::t_in_item  i_item,
    input  sjte_pkg::t_cursor   i_cur,
    input  sjte_pkg::t_cfg      i_cfg,
    output sjte_pkg::t_step_out o_step
);

    localparam logic [7:0] ColLimit = 8'(COLUMNS);
    localparam logic [7:0] LastCol  = 8'(COLUMNS - 1);

    typedef struct packed {
        sjte_pkg::t_cursor st;
        logic [2:0]        cnt;
        sjte_pkg::t_result [sjte_pkg::MAX_RESULTS-1:0] res;
    } t_ctx;

    function automatic t_ctx f_emit(input t_ctx c, input logic [1:0] kind,
                                    input logic [15:0] glyph, input logic [7:0] col,
                                    input logic [7:0] row, input logic [7:0] color);
        if (c.cnt < 3'(sjte_pkg::MAX_RESULTS)) begin
            c.res[c.cnt[1:0]].kind       = kind;
            c.res[c.cnt[1:0]].glyph_code = glyph;
            c.res[c.cnt[1:0]].cell_col   = col;
            c.res[c.cnt[1:0]].cell_row   = row;
            c.res[c.cnt[1:0]].fill_color = color;
            c.res[c.cnt[1:0]].last       = 1'b0;
            c.cnt = c.cnt + 3'd1;
        end
        return c;
    endfunction

    function automatic t_ctx f_newline(input t_ctx c, input sjte_pkg::t_cfg cfg);
        c.st.col  = 8'd0;
        c.st.wrap = 1'b0;
        if (c.st.row >= {3'b000, cfg.last_row}) begin
            if (cfg.window_enable) begin
                c = f_emit(c, sjte_pkg::KIND_SCROLL, 16'h0000, 8'h00, 8'h00,
                           sjte_pkg::SCROLL_FILL);
            end
            c.st.row = {3'b000, cfg.last_row};
        end else begin
            c.st.row = c.st.row + 8'd1;
        end
        return c;
    endfunction

    function automatic t_ctx f_put_glyph(input t_ctx c, input sjte_pkg::t_cfg cfg,
                                         input logic [15:0] code);
        logic outside;
        outside = (c.st.row < {3'b000, cfg.top_row}) ||
                  (c.st.row > {3'b000, cfg.last_row});
        if (!(cfg.window_enable && outside)) begin
            if (cfg.auto_wrap && c.st.wrap) begin
                c = f_newline(c, cfg);
            end
            c = f_emit(c, sjte_pkg::KIND_DRAW, code, c.st.col, c.st.row, cfg.text_color);
            c.st.col = c.st.col + 8'd1;
            if (cfg.auto_wrap && (c.st.col >= ColLimit)) begin
                c.st.col  = LastCol;
                c.st.wrap = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic t_ctx f_backspace(input t_ctx c, input sjte_pkg::t_cfg cfg);
        logic moved;
        moved = 1'b0;
        if (c.st.lead != 8'h00) begin
            c.st.lead = 8'h00;
        end else if (c.st.wrap) begin
            c.st.wrap = 1'b0;
        end else begin
            if (c.st.col != 8'd0) begin
                c.st.col = c.st.col - 8'd1;
                moved    = 1'b1;
            end else if (c.st.row > {3'b000, cfg.top_row}) begin
                c.st.row = c.st.row - 8'd1;
                c.st.col = LastCol;
                moved    = 1'b1;
            end
            // space drawn inside the window regardless of window_enable
            if (moved && (c.st.row >= {3'b000, cfg.top_row}) &&
                (c.st.row <= {3'b000, cfg.last_row})) begin
                c = f_emit(c, sjte_pkg::KIND_DRAW, {8'h00, sjte_pkg::CHAR_SPACE},
                           c.st.col, c.st.row, cfg.text_color);
            end
        end
        return c;
    endfunction

    function automatic t_ctx f_text(input t_ctx c, input sjte_pkg::t_cfg cfg,
                                    input logic [7:0] b);
        logic done;
        done = 1'b0;
        if (c.st.lead != 8'h00) begin
            if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
                c    = f_put_glyph(c, cfg, {c.st.lead, b});
                done = 1'b1;
            end else begin
                // bad trail byte: flush lead alone, then treat byte as new
                c = f_put_glyph(c, cfg, {8'h00, c.st.lead});
            end
            c.st.lead = 8'h00;
        end
        if (!done) begin
            if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
                c.st.lead = b;
            end else if (b == sjte_pkg::CHAR_BS) begin
                c = f_backspace(c, cfg);
            end else if (b == sjte_pkg::CHAR_CR) begin
                c = f_newline(c, cfg);
            end else if ((b >= 8'hA1 && b <= 8'hDF) || (b >= 8'h20 && b <= 8'h7E)) begin
                c = f_put_glyph(c, cfg, {8'h00, b});
            end
        end
        return c;
    endfunction

    t_ctx       ctx;
    logic [2:0] last_idx;

    always_comb begin
        ctx     = '0;
        ctx.st  = i_cur;
        unique case (i_item.mode)
            sjte_pkg::MODE_TEXT: begin
                ctx = f_text(ctx, i_cfg, i_item.text_byte);
            end
            sjte_pkg::MODE_LOCATE: begin
                ctx.st.col  = {2'b00, i_item.locate_col};
                ctx.st.row  = {3'b000, i_item.locate_row};
                ctx.st.wrap = 1'b0;
            end
            sjte_pkg::MODE_CLEAR: begin
                ctx = f_emit(ctx, sjte_pkg::KIND_CLEAR, 16'h0000, 8'h00, 8'h00,
                             i_cfg.text_color);
                ctx.st.col  = 8'd0;
                ctx.st.row  = {3'b000, i_cfg.top_row};
                ctx.st.lead = 8'h00;
                ctx.st.wrap = 1'b0;
            end
            default: begin
            end
        endcase
        last_idx = ctx.cnt - 3'd1;
        if (ctx.cnt != 3'd0) begin
            ctx.res[last_idx[1:0]].last = 1'b1;
        end
        o_step.nxt = ctx.st;
        o_step.cnt = ctx.cnt;
        o_step.res = ctx.res;
    end

endmodule

// File: design/sjte_out_buf.sv
// result buffer: holds the results of one item and sends them one beat at a time
module sjte_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [2:0]          i_cnt,
    input  sjte_pkg::t_result [sjte_pkg::MAX_RESULTS-1:0] i_res,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output sjte_pkg::t_result   o_res
);

    sjte_pkg::t_result [sjte_pkg::MAX_RESULTS-1:0] r_res;
    logic [2:0] r_left;
    logic [1:0] r_idx;

    assign o_valid    = (r_left != 3'd0);
    assign o_can_load = (r_left == 3'd0) || ((r_left == 3'd1) && i_ready);
    assign o_res      = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_left <= i_cnt;
            r_idx  <= 2'd0;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: design/sjis_text_cursor_engine_core.sv
// top level of the shift-jis text cursor engine
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: mode; tdata: text byte, locate col/row
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: kind; tdata: glyph, col, row, color
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// an accepted beat lands in the input register; the next cycle it is evaluated in
// one pass and its zero to four results go into the result buffer together
// the single result port sets the rate: results go out one at a time, and an item
// with no result leaves the input register without waiting for buffer room
// synchronous active-low reset clears cursor, lead byte and wrap flag and loads
// the config defaults
// a stalled m_axis holds the buffer; one more beat waits in the input register
module sjis_text_cursor_engine_core #(
    parameter int COLUMNS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // text_byte[7:0], locate_col[13:8], locate_row[18:14]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // glyph_code[15:0], cell_col[23:16], cell_row[31:24],
                                        // fill_color[39:32]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    sjte_pkg::t_in_item  in_item;
    sjte_pkg::t_in_item  reg_item;
    logic                reg_valid;
    logic                take;
    logic                load;
    logic                can_load;
    sjte_pkg::t_step_out step;
    sjte_pkg::t_result   out_res;

    sjte_pkg::t_cursor   r_cur;
    sjte_pkg::t_cfg      r_cfg;

    // unpack the input beat
    assign in_item.mode       = s_axis_tuser;
    assign in_item.text_byte  = s_axis_tdata[7:0];
    assign in_item.locate_col = s_axis_tdata[13:8];
    assign in_item.locate_row = s_axis_tdata[18:14];

    sjte_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (take)
    );

    sjte_step #(
        .COLUMNS (COLUMNS)
    ) u_step (
        .i_item (reg_item),
        .i_cur  (r_cur),
        .i_cfg  (r_cfg),
        .o_step (step)
    );

    // an item leaves the input register when its results fit in the buffer;
    // items without results need no buffer room
    assign take = reg_valid && ((step.cnt == 3'd0) || can_load);
    assign load = take && (step.cnt != 3'd0);

    sjte_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_cnt      (step.cnt),
        .i_res      (step.res),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res)
    );

    assign m_axis_tdata = {out_res.fill_color, out_res.cell_row, out_res.cell_col,
                           out_res.glyph_code};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    // cursor state advances when an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (take) begin
            r_cur <= step.nxt;
        end
    end

    // configuration registers, always ready; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_row       <= 5'd0;
            r_cfg.last_row      <= 5'd24;
            r_cfg.window_enable <= 1'b0;
            r_cfg.auto_wrap     <= 1'b0;
            r_cfg.text_color    <= 8'h10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sjte_pkg::REG_TOP_ROW:    r_cfg.top_row       <= i_cfg_data[4:0];
                sjte_pkg::REG_LAST_ROW:   r_cfg.last_row      <= i_cfg_data[4:0];
                sjte_pkg::REG_WIN_EN:     r_cfg.window_enable <= i_cfg_data[0];
                sjte_pkg::REG_AUTO_WRAP:  r_cfg.auto_wrap     <= i_cfg_data[0];
                sjte_pkg::REG_TEXT_COLOR: r_cfg.text_color    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: dv/sjis_text_cursor_engine_checker.sv
// checker: predicts the draw, scroll and clear commands of the text cursor engine and compares them
module sjis_text_cursor_engine_checker #(
    parameter int COLUMNS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,
    input  logic [1:0]  i_out_user,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_scroll_count
);
    timeunit 1ns;
    timeprecision 1ps;

    sjte_pkg::t_cfg cfg_q;
    logic [7:0]     cur_col;
    logic [7:0]     cur_row;
    logic [7:0]     lead_b;
    logic           wrap_pend;

    sjte_pkg::t_result step_buf [sjte_pkg::MAX_RESULTS];
    int                step_n;
    sjte_pkg::t_result pending_cmds [$];

    int fail_total   = 0;
    int result_total = 0;
    int scroll_total = 0;

    task automatic reset_model();
        cfg_q.top_row       = 5'd0;
        cfg_q.last_row      = 5'd24;
        cfg_q.window_enable = 1'b0;
        cfg_q.auto_wrap     = 1'b0;
        cfg_q.text_color    = 8'h10;
        cur_col   = 8'd0;
        cur_row   = 8'd0;
        lead_b    = 8'd0;
        wrap_pend = 1'b0;
    endtask

    task automatic push_cmd(input logic [1:0] kind, input logic [15:0] glyph,
                            input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] color);
        sjte_pkg::t_result r;
        r.kind       = kind;
        r.glyph_code = glyph;
        r.cell_col   = col;
        r.cell_row   = row;
        r.fill_color = color;
        r.last       = 1'b0;
        if (step_n < sjte_pkg::MAX_RESULTS) begin
            step_buf[step_n] = r;
            step_n++;
        end
    endtask

    function automatic bit row_in_band();
        return cur_row >= {3'd0, cfg_q.top_row} && cur_row <= {3'd0, cfg_q.last_row};
    endfunction

    task automatic line_feed();
        cur_col   = 8'd0;
        wrap_pend = 1'b0;
        if (cur_row >= {3'd0, cfg_q.last_row}) begin
            if (cfg_q.window_enable)
                push_cmd(sjte_pkg::KIND_SCROLL, 16'd0, 8'd0, 8'd0, sjte_pkg::SCROLL_FILL);
            cur_row = {3'd0, cfg_q.last_row};
        end else begin
            cur_row = cur_row + 8'd1;
        end
    endtask

    task automatic place_glyph(input logic [15:0] code);
        if (cfg_q.window_enable && !row_in_band())
            return;
        if (cfg_q.auto_wrap && wrap_pend)
            line_feed();
        push_cmd(sjte_pkg::KIND_DRAW, code, cur_col, cur_row, cfg_q.text_color);
        cur_col = cur_col + 8'd1;
        if (cfg_q.auto_wrap && cur_col >= 8'(COLUMNS)) begin
            cur_col   = 8'(COLUMNS - 1);
            wrap_pend = 1'b1;
        end
    endtask

    task automatic rub_out();
        if (lead_b != 8'd0) begin
            lead_b = 8'd0;
            return;
        end
        if (wrap_pend) begin
            wrap_pend = 1'b0;
            return;
        end
        if (cur_col != 8'd0) begin
            cur_col = cur_col - 8'd1;
        end else if (cur_row > {3'd0, cfg_q.top_row}) begin
            cur_row = cur_row - 8'd1;
            cur_col = 8'(COLUMNS - 1);
        end else begin
            return;
        end
        // the blank is drawn inside the band even with bounds check off
        if (!row_in_band())
            return;
        push_cmd(sjte_pkg::KIND_DRAW, {8'd0, sjte_pkg::CHAR_SPACE}, cur_col, cur_row,
                 cfg_q.text_color);
    endtask

    task automatic take_byte(input logic [7:0] b);
        if (lead_b != 8'd0) begin
            // trail ranges 0x40..0x7e and 0x80..0xfc
            if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
                place_glyph({lead_b, b});
                lead_b = 8'd0;
                return;
            end
            // bad trail: flush the lead alone, then treat b as fresh
            place_glyph({8'd0, lead_b});
            lead_b = 8'd0;
        end
        if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC))
            lead_b = b;
        else if (b == sjte_pkg::CHAR_BS)
            rub_out();
        else if (b == sjte_pkg::CHAR_CR)
            line_feed();
        else if ((b >= 8'hA1 && b <= 8'hDF) || (b >= 8'h20 && b <= 8'h7E))
            place_glyph({8'd0, b});
    endtask

    task automatic predict_beat(input logic [1:0] mode, input logic [23:0] data);
        step_n = 0;
        case (mode)
            sjte_pkg::MODE_TEXT: take_byte(data[7:0]);
            sjte_pkg::MODE_LOCATE: begin
                cur_col   = {2'd0, data[13:8]};
                cur_row   = {3'd0, data[18:14]};
                wrap_pend = 1'b0;
            end
            sjte_pkg::MODE_CLEAR: begin
                push_cmd(sjte_pkg::KIND_CLEAR, 16'd0, 8'd0, 8'd0, cfg_q.text_color);
                cur_col   = 8'd0;
                cur_row   = {3'd0, cfg_q.top_row};
                lead_b    = 8'd0;
                wrap_pend = 1'b0;
            end
            default: ;
        endcase
        if (step_n > 0)
            step_buf[step_n-1].last = 1'b1;
        for (int k = 0; k < step_n; k++)
            pending_cmds.push_back(step_buf[k]);
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            sjte_pkg::REG_TOP_ROW:    cfg_q.top_row       = val[4:0];
            sjte_pkg::REG_LAST_ROW:   cfg_q.last_row      = val[4:0];
            sjte_pkg::REG_WIN_EN:     cfg_q.window_enable = val[0];
            sjte_pkg::REG_AUTO_WRAP:  cfg_q.auto_wrap     = val[0];
            sjte_pkg::REG_TEXT_COLOR: cfg_q.text_color    = val;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_result();
        sjte_pkg::t_result want;
        if (pending_cmds.size() == 0) begin
            $error("result beat with nothing pending: kind %0d tdata %h", i_out_user, i_out_data);
            fail_total++;
            return;
        end
        want = pending_cmds.pop_front();
        result_total++;
        if (want.kind == sjte_pkg::KIND_SCROLL)
            scroll_total++;
        check_field("kind",       16'(want.kind),       16'(i_out_user));
        check_field("glyph_code", want.glyph_code,      i_out_data[15:0]);
        check_field("cell_col",   16'(want.cell_col),   16'(i_out_data[23:16]));
        check_field("cell_row",   16'(want.cell_row),   16'(i_out_data[31:24]));
        check_field("fill_color", 16'(want.fill_color), 16'(i_out_data[39:32]));
        check_field("last",       16'(want.last),       16'(i_out_last));
    endtask

    // results leave only after passing the input register and the result buffer, so compare before predicting
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            pending_cmds.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_cfg_valid && i_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                predict_beat(i_in_user, i_in_data);
        end
        o_pending      <= pending_cmds.size();
        o_fail_count   <= fail_total;
        o_result_count <= result_total;
        o_scroll_count <= scroll_total;
    end

endmodule

// File: dv/sjis_text_cursor_engine_core_tb.sv
// testbench top: drives text, locate, clear and register beats into the cursor engine
module sjis_text_cursor_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         COLUMNS     = 40;
    localparam int         CYCLE_LIMIT = 600000;
    // the one mode code the engine ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // text_byte[7:0], locate_col[13:8], locate_row[18:14]
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // glyph_code[15:0], cell_col[23:16], cell_row[31:24],
                                 // fill_color[39:32]
    logic [1:0]  m_axis_tuser;   // kind[1:0]
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int scroll_count;

    // bookkeeping for the summary and the random phases
    int          beats_sent   = 0;
    int          cfg_writes   = 0;
    int          random_beats = 0;
    int unsigned cycle_count  = 0;
    // calm: no idling on either side
    bit          calm         = 1'b0;

    sjis_text_cursor_engine_core #(
        .COLUMNS(COLUMNS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sjis_text_cursor_engine_checker #(
        .COLUMNS(COLUMNS)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_user      (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_user     (m_axis_tuser),
        .i_out_last     (m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_scroll_count (scroll_count)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sjis_text_cursor_engine_core_tb: done, errors");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_printable();
        // half-width katakana block or plain ascii
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(8'hA1, 8'hDF));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] pick_lead();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h81, 8'h9F));
        return 8'($urandom_range(8'hE0, 8'hFC));
    endfunction

    function automatic logic [7:0] pick_trail();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h40, 8'h7E));
        return 8'($urandom_range(8'h80, 8'hFC));
    endfunction

    // result side: random stalls between ready cycles
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall_left = idle_len();
            end
        end
    end

    // one input beat; valid stays high into the next beat when no gap follows
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] text_b,
                             input logic [5:0] col, input logic [4:0] row);
        int gap;
        s_axis_tuser  = mode;
        s_axis_tdata  = {5'd0, row, col, text_b};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // text beat with junk in the unused locate fields
    task automatic send_text(input logic [7:0] text_b);
        send_beat(sjte_pkg::MODE_TEXT, text_b, 6'($urandom), 5'($urandom));
    endtask

    task automatic send_locate(input logic [5:0] col, input logic [4:0] row);
        send_beat(sjte_pkg::MODE_LOCATE, 8'($urandom), col, row);
    endtask

    task automatic send_clear();
        send_beat(sjte_pkg::MODE_CLEAR, 8'($urandom), 6'($urandom), 5'($urandom));
    endtask

    // hold off until every expected result is out and until a beat that causes
    // nothing, which may still sit in the input register, has left it too
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // write all five registers back to back while the engine is idle;
    // spare upper data bits carry junk that must be ignored
    task automatic load_config(input logic [4:0] top, input logic [4:0] bot,
                               input logic win, input logic wrap,
                               input logic [7:0] color);
        logic [2:0] idx  [5];
        logic [7:0] vals [5];
        logic [7:0] junk;
        settle();
        junk    = 8'($urandom);
        idx[0]  = sjte_pkg::REG_TOP_ROW;
        vals[0] = {junk[7:5], top};
        idx[1]  = sjte_pkg::REG_LAST_ROW;
        vals[1] = {junk[4:2], bot};
        idx[2]  = sjte_pkg::REG_WIN_EN;
        vals[2] = {junk[7:1], win};
        idx[3]  = sjte_pkg::REG_AUTO_WRAP;
        vals[3] = {junk[6:0], wrap};
        idx[4]  = sjte_pkg::REG_TEXT_COLOR;
        vals[4] = color;
        for (int k = 0; k < 5; k++) begin
            i_cfg_index = idx[k];
            i_cfg_data  = vals[k];
            i_cfg_valid = 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            @(negedge i_clk);
            cfg_writes++;
        end
        i_cfg_valid = 1'b0;
    endtask

    // one random stimulus unit: mostly well-formed text, some noise and
    // broken double-byte sequences
    task automatic send_mixed_item();
        int r;
        int counted;
        logic [5:0] col;
        logic [4:0] row;
        r       = $urandom_range(0, 99);
        counted = 1;
        if (r < 40) begin
            send_text(pick_printable());
        end else if (r < 62) begin
            // proper lead + trail pair
            send_text(pick_lead());
            send_text(pick_trail());
            counted = 2;
        end else if (r < 70) begin
            send_text(sjte_pkg::CHAR_CR);
        end else if (r < 77) begin
            send_text(sjte_pkg::CHAR_BS);
        end else if (r < 84) begin
            // bias toward the right edge so wraps happen, sometimes off screen
            case ($urandom_range(0, 3))
                0:       col = 6'($urandom);
                1:       col = 6'($urandom_range(34, 39));
                default: col = 6'($urandom_range(0, 39));
            endcase
            row = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 24));
            send_locate(col, row);
        end else if (r < 86) begin
            send_clear();
        end else if (r < 88) begin
            send_beat(MODE_UNUSED, 8'($urandom), 6'($urandom), 5'($urandom));
            counted = 0;
        end else if (r < 94) begin
            // lead followed by anything, often a bad trail
            send_text(pick_lead());
            send_text(8'($urandom));
            counted = 2;
        end else begin
            send_text(8'($urandom));
        end
        random_beats += counted;
    endtask

    task automatic fill_random(input int n);
        random_beats = 0;
        while (random_beats < n)
            send_mixed_item();
    endtask

    task automatic run_phase(input int p);
        case (p)
            0:       load_config(5'd0, 5'd24, 1'b1, 1'b1, 8'($urandom));
            // inverted band with bounds check on
            1:       load_config(5'd24, 5'd0, 1'b1, 1'b0, 8'($urandom));
            2:       load_config(5'($urandom), 5'($urandom), 1'($urandom), 1'($urandom),
                                 8'($urandom));
            3:       load_config(5'd0, 5'd31, 1'b0, 1'b1, 8'hFF);
            4:       load_config(5'd31, 5'd31, 1'b1, 1'b1, 8'h00);
            default: load_config(5'd0, 5'd24, 1'b0, 1'b0, 8'($urandom));
        endcase
        calm = (p == 3);
        fill_random(11);
        // sender waits for the engine to drain mid-phase
        settle();
        fill_random(11);
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sjte_pkg::MODE_TEXT;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = sjte_pkg::REG_TOP_ROW;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: printable extremes
        send_text(8'h20);
        send_text(8'h7E);
        send_text(8'hA1);
        send_text(8'hDF);
        // double-byte extremes of both lead ranges
        send_text(8'h81);
        send_text(8'h40);
        send_text(8'h9F);
        send_text(8'h7E);
        send_text(8'hE0);
        send_text(8'h80);
        send_text(8'hFC);
        send_text(8'hFC);
        // bad trail that is printable itself, and one that is a newline
        send_text(8'h88);
        send_text(8'h3F);
        send_text(8'hE5);
        send_text(sjte_pkg::CHAR_CR);
        // bytes that draw nothing
        send_text(8'h7F);
        send_text(8'hA0);
        send_text(8'hFF);
        send_text(8'h00);
        // backspace at the start of a line, then at the home position
        send_text(sjte_pkg::CHAR_BS);
        send_locate(6'd0, 5'd0);
        send_text(sjte_pkg::CHAR_BS);
        // cursor beyond the screen is kept as is
        send_locate(6'd63, 5'd31);
        send_text(8'h41);
        send_beat(MODE_UNUSED, 8'hFF, 6'h3F, 5'h1F);
        send_clear();

        // small band with bounds check and auto-wrap
        load_config(5'd2, 5'd4, 1'b1, 1'b1, 8'hFF);
        send_locate(6'd38, 5'd2);
        send_text(8'h41);
        send_text(8'h42);
        // backspace only cancels the deferred wrap
        send_text(sjte_pkg::CHAR_BS);
        send_text(8'h43);
        send_text(8'h44);
        // newline on the bottom row scrolls
        send_locate(6'd0, 5'd4);
        send_text(sjte_pkg::CHAR_CR);
        // backspace from column 0 goes to the end of the row above
        send_locate(6'd0, 5'd3);
        send_text(sjte_pkg::CHAR_BS);
        // outside the band nothing is drawn
        send_locate(6'd5, 5'd10);
        send_text(8'h41);
        send_clear();

        // empty window: clear still goes out
        load_config(5'd20, 5'd3, 1'b0, 1'b0, 8'h00);
        send_clear();
        send_text(8'h41);
        send_text(sjte_pkg::CHAR_CR);

        for (int p = 0; p < 6; p++)
            run_phase(p);

        settle();
        repeat (10) @(negedge i_clk);

        $display("run covered %0d input beats and %0d register writes over nine settings,",
                 beats_sent, cfg_writes);
        $display("  %0d result beats checked, %0d of them scrolls", result_count, scroll_count);
        if (fail_count == 0)
            $display("sjis_text_cursor_engine_core_tb: done, clean");
        else
            $display("sjis_text_cursor_engine_core_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
design/sjte_pkg.sv
design/sjte_in_reg.sv
design/sjte_step.sv
design/sjte_out_buf.sv
design/sjis_text_cursor_engine_core.sv
dv/sjis_text_cursor_engine_checker.sv
dv/sjis_text_cursor_engine_core_tb.sv
